>>> hw/rtl/tbs_pkg.sv
// Shared types, marker tables and sizing constants for the think block stripper.
package tbs_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MATCH_W       = 3;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [MATCH_W-1:0] BEGIN_LAST = MATCH_W'(6);  // index of '>' in "<think>"
  localparam logic [MATCH_W-1:0] END_LAST   = MATCH_W'(7);  // index of '>' in "</think>"
  localparam logic [BYTE_W-1:0]  CHAR_LT    = 8'h3C;        // '<'

  typedef enum logic {
    CMD_TEXT = 1'b0,
    CMD_EOR  = 1'b1
  } cmd_e;

  // One request for the back part: release pre_cnt bytes of the begin marker,
  // then optionally the current byte.
  typedef struct packed {
    logic [MATCH_W-1:0] pre_cnt;
    logic               emit_cur;
    logic [BYTE_W-1:0]  cur_byte;
  } job_t;

  function automatic logic [BYTE_W-1:0] begin_char(input logic [MATCH_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;  // <
      3'd1:    ch = 8'h74;  // t
      3'd2:    ch = 8'h68;  // h
      3'd3:    ch = 8'h69;  // i
      3'd4:    ch = 8'h6E;  // n
      3'd5:    ch = 8'h6B;  // k
      3'd6:    ch = 8'h3E;  // >
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] end_char(input logic [MATCH_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;  // <
      3'd1:    ch = 8'h2F;  // /
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h68;  // h
      3'd4:    ch = 8'h69;  // i
      3'd5:    ch = 8'h6E;  // n
      3'd6:    ch = 8'h6B;  // k
      default: ch = 8'h3E;  // >
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/tbs_front.sv
// Front part: accepts requests, tracks marker matching, queues release jobs.
module tbs_front import tbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  input  logic [BYTE_W-1:0]   in_byte_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output job_t                q_job_o
);

  logic               inside_q, inside_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic               accept;
  logic               is_lt;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_lt      = (in_byte_i == CHAR_LT);

  always_comb begin
    inside_d          = inside_q;
    match_d           = match_q;
    q_push_o          = 1'b0;
    q_job_o.pre_cnt   = '0;
    q_job_o.emit_cur  = 1'b0;
    q_job_o.cur_byte  = in_byte_i;
    if (accept) begin
      if (cmd_e'(in_cmd_i) == CMD_EOR) begin
        // drop any held partial marker
        inside_d = 1'b0;
        match_d  = '0;
      end else if (inside_q) begin
        if (in_byte_i == end_char(match_q)) begin
          if (match_q == END_LAST) begin
            inside_d = 1'b0;
            match_d  = '0;
          end else begin
            match_d = match_q + MATCH_W'(1);
          end
        end else begin
          match_d = is_lt ? MATCH_W'(1) : '0;
        end
      end else if (match_q <= BEGIN_LAST && in_byte_i == begin_char(match_q)) begin
        if (match_q == BEGIN_LAST) begin
          inside_d = 1'b1;
          match_d  = '0;
        end else begin
          match_d = match_q + MATCH_W'(1);
        end
      end else begin
        // broken begin match: release prefix, hold a fresh '<'
        q_job_o.pre_cnt  = (match_q > BEGIN_LAST) ? BEGIN_LAST : match_q;
        q_job_o.emit_cur = ~is_lt;
        match_d          = is_lt ? MATCH_W'(1) : '0;
        q_push_o         = (q_job_o.pre_cnt != '0) | q_job_o.emit_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      match_q  <= '0;
    end else begin
      inside_q <= inside_d;
      match_q  <= match_d;
    end
  end

endmodule

>>> hw/rtl/tbs_fifo.sv
// Small register queue of release jobs between the front and back parts.
module tbs_fifo import tbs_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & valid_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

>>> hw/rtl/tbs_back.sv
// Back part: expands each job into bytes, one per cycle unless stalled.
module tbs_back import tbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  input  logic              out_ready_i
);

  job_t               job_q;
  logic               job_valid_q;
  logic [MATCH_W-1:0] idx_q;
  logic [MATCH_W-1:0] total;
  logic               is_last;
  logic               out_load;
  logic               emit;
  logic [BYTE_W-1:0]  byte_sel;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;

  assign total    = job_q.pre_cnt + MATCH_W'(job_q.emit_cur);
  assign is_last  = (idx_q == total - MATCH_W'(1));
  assign out_load = ~out_valid_q | out_ready_i;
  assign emit     = job_valid_q & out_load;
  assign q_pop_o  = q_valid_i & (~job_valid_q | (emit & is_last));
  assign byte_sel = (idx_q < job_q.pre_cnt) ? begin_char(idx_q) : job_q.cur_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (emit) begin
        job_valid_q <= ~is_last;
        idx_q       <= idx_q + MATCH_W'(1);
      end
      if (out_load) out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
    if (emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

>>> hw/rtl/think_block_stripper.sv
// Top level of the think block stripper: streaming filter removing <think> regions.
//
// Usage:
//   Input stream s_axis: one request per byte. tdata carries the text byte,
//   tuser carries the command (0 = text byte, 1 = end of response, which clears
//   the region flag and discards any held partial begin marker).
//   Output stream m_axis: the filtered text, one byte per transfer. tlast marks
//   the final byte produced by one input request.
//   Bytes inside a "<think>" ... "</think>" region, both markers included, are
//   dropped. Bytes that could start "<think>" are held and released, ahead of
//   the current byte, once the match breaks.
// Throughput: one input request per cycle while the job queue has room; the
//   back part emits one byte per cycle while m_axis_tready is high. A request
//   that releases a held prefix yields up to 7 bytes.
// Path: the first byte of a request reaches m_axis through the queue write at
//   the accepting edge, the job register and the output register.
// Stall: when m_axis_tready is low the output register holds; the job queue
//   (FIFO_DEPTH entries) absorbs requests until full, then s_axis_tready drops.
// Reset: rst_ni clears the region flag, match count, queue and output valid.
module think_block_stripper import tbs_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] text_byte
  input  logic              s_axis_tuser,   // [0] cmd
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast    // last_of_run
);

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, pop_job;

  // Classify each request and keep marker state
  tbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  // Decouple classification from byte emission
  tbs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // Expand jobs into the output stream
  tbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

>>> hw/rtl/tbs_checker.sv
// Port-level checker for the think block stripper and its bind.
module tbs_checker import tbs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [BYTE_W-1:0] s_axis_tdata,
  input logic              s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [BYTE_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output request changed");

  // No output once reset has been seen at an edge
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // Every byte before the last of a run is part of a released begin-marker prefix
  a_prefix_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tdata == 8'h3C || m_axis_tdata == 8'h74 || m_axis_tdata == 8'h68 ||
       m_axis_tdata == 8'h69 || m_axis_tdata == 8'h6E || m_axis_tdata == 8'h6B))
    else $error("non-final output byte is not a begin-marker prefix byte");

  // Input ready comes back right after reset
  a_ready_after_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind think_block_stripper tbs_checker u_tbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/think_block_stripper_tb.sv
// Self-checking testbench for the think block stripper, with a marker-tracking scoreboard.
`timescale 1ns / 100ps

module think_block_stripper_tb;
  import tbs_pkg::*;

  localparam int unsigned RUN_REQUESTS = 430;     // directed part plus random traffic
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned SETTLE       = 8;
  localparam logic [7:0]  LT_CHAR      = 8'h3C;

  // One expected byte on the filtered stream.
  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
  } text_beat_t;

  // Tracks region and marker state exactly as the block should, and holds the
  // bytes it owes the output stream in order.
  class strip_scoreboard;
    localparam logic [55:0] OPEN_TAG  = "<think>";
    localparam logic [63:0] CLOSE_TAG = "</think>";

    bit          in_region;
    int unsigned tag_pos;
    text_beat_t  owed_q[$];
    int unsigned errors, requests, eor_count, opened, closed;
    int unsigned releases, longest_run, bytes_checked;

    function logic [7:0] open_char(int unsigned i);
      return OPEN_TAG[8*(6-i) +: 8];
    endfunction

    function logic [7:0] close_char(int unsigned i);
      return CLOSE_TAG[8*(7-i) +: 8];
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the marker state for one accepted request and queue its bytes.
    function void note_request(cmd_e cmd, logic [7:0] ch);
      int unsigned held, total;
      text_beat_t  beat;
      requests++;
      if (cmd == CMD_EOR) begin
        in_region = 1'b0;
        tag_pos   = 0;
        eor_count++;
        return;
      end
      if (in_region) begin
        if (ch == close_char(tag_pos)) begin
          tag_pos++;
          if (tag_pos == 8) begin
            in_region = 1'b0;
            tag_pos   = 0;
            closed++;
          end
        end else begin
          tag_pos = (ch == LT_CHAR) ? 1 : 0;
        end
        return;
      end
      if (ch == open_char(tag_pos)) begin
        tag_pos++;
        if (tag_pos == 7) begin
          in_region = 1'b1;
          tag_pos   = 0;
          opened++;
        end
        return;
      end
      // Broken begin match: release the held prefix, then the byte unless it is '<'.
      held  = tag_pos;
      total = held + ((ch == LT_CHAR) ? 0 : 1);
      for (int unsigned k = 0; k < total; k++) begin
        beat.ch      = (k < held) ? open_char(k) : ch;
        beat.run_end = (k == total - 1);
        owed_q.insert(owed_q.size(), beat);
      end
      if (held > 0) releases++;
      if (total > longest_run) longest_run = total;
      tag_pos = (ch == LT_CHAR) ? 1 : 0;
    endfunction

    function void check_byte(logic [7:0] ch, logic run_end);
      text_beat_t want;
      bytes_checked++;
      if (owed_q.size() == 0) begin
        $display("%0t: out_byte expected none actual %02h (tlast %0b)", $time, ch, run_end);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.ch, ch);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, want.run_end, run_end);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = CMD_TEXT;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  strip_scoreboard sb = new();

  int unsigned cycle_cnt      = 0;
  int unsigned burst_left     = 0;
  bit          sender_idle_en = 1'b1;
  int unsigned drains         = 0;
  logic [15:0] rx_pattern     = 16'hFFFF;
  logic [3:0]  rx_phase       = 4'd0;

  think_block_stripper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, sb.pending());
      $display("think_block_stripper: mismatch");
      $finish;
    end
  end

  // Receiver: replay a 16-bit ready pattern, picking a fresh one at each wrap.
  always @(negedge clk_i) begin
    if (rx_phase == 4'd0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: rx_pattern = 16'hFFFF;
        3:       rx_pattern = 16'h0101;
        4:       rx_pattern = 16'h0000;
        default: rx_pattern = 16'($urandom);
      endcase
    end
    m_axis_tready <= rx_pattern[rx_phase];
    rx_phase = rx_phase + 4'd1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
  end

  // Present one request and hold it until accepted; open a gap first when a burst ends.
  task automatic send_request(cmd_e cmd, logic [7:0] ch);
    int unsigned gap;
    if (sender_idle_en && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, ch);
  endtask

  // Send count characters of a marker starting at index from.
  task automatic send_marker(bit closing, int unsigned from, int unsigned count);
    for (int unsigned i = from; i < from + count; i++)
      send_request(CMD_TEXT, closing ? sb.close_char(i) : sb.open_char(i));
  endtask

  // Hold off the sender until the filtered stream has caught up.
  task automatic drain_output();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    drains++;
  endtask

  // Favor marker characters so partial matches show up often.
  function automatic logic [7:0] pick_text();
    if ($urandom_range(0, 3) == 0) return sb.close_char($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // A byte that breaks a marker match after pos characters.
  function automatic logic [7:0] pick_breaker(bit closing, int unsigned pos);
    logic [7:0] b;
    if ($urandom_range(0, 9) < 3) return LT_CHAR;
    b = pick_text();
    if (b == (closing ? sb.close_char(pos) : sb.open_char(pos))) b = b ^ 8'h01;
    return b;
  endfunction

  initial begin
    int unsigned len, p;
    bit          failed;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, a re-held '<', a long release, discard on end of
    // response, then a full region closed after a false '<' start.
    send_request(CMD_TEXT, 8'h00);
    send_request(CMD_TEXT, LT_CHAR);
    send_request(CMD_TEXT, LT_CHAR);
    send_marker(1'b0, 1, 4);
    send_request(CMD_TEXT, 8'hFF);
    send_request(CMD_TEXT, LT_CHAR);
    send_request(CMD_EOR, 8'hA5);
    send_marker(1'b0, 0, 7);
    send_request(CMD_TEXT, LT_CHAR);
    send_marker(1'b1, 0, 8);
    drain_output();

    while (sb.requests < RUN_REQUESTS) begin
      if ($urandom_range(0, 99) < 15) sender_idle_en = !sender_idle_en;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 8);
          repeat (len) send_request(CMD_TEXT, pick_text());
        end
        5, 6, 7, 8, 9, 10: begin
          send_marker(1'b0, 0, 7);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
              repeat ($urandom_range(0, 6)) send_request(CMD_TEXT, pick_text());
            end else begin
              p = $urandom_range(1, 7);
              send_marker(1'b1, 0, p);
              send_request(CMD_TEXT, pick_breaker(1'b1, p));
            end
          end
          case ($urandom_range(0, 19))
            0, 1:    send_request(CMD_EOR, 8'($urandom_range(0, 255)));
            2:       ;  // leave the region open
            default: send_marker(1'b1, 0, 8);
          endcase
        end
        11, 12, 13, 14: begin
          p = ($urandom_range(0, 2) == 0) ? 6 : $urandom_range(1, 6);
          send_marker(1'b0, 0, p);
          send_request(CMD_TEXT, pick_breaker(1'b0, p));
        end
        15, 16: begin
          send_marker(1'b0, 0, $urandom_range(0, 6));
          send_request(CMD_EOR, 8'($urandom_range(0, 255)));
        end
        17, 18: repeat ($urandom_range(2, 5)) send_request(CMD_TEXT, LT_CHAR);
        default: drain_output();
      endcase
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    failed = (sb.errors != 0) || (sb.pending() != 0);
    if (sb.pending() != 0) $display("%0d expected bytes never arrived", sb.pending());
    $display("run: %0d requests (%0d end-of-response), %0d bytes checked, %0d drains",
             sb.requests, sb.eor_count, sb.bytes_checked, drains);
    $display("run: %0d regions opened, %0d closed, %0d prefix releases, longest run %0d",
             sb.opened, sb.closed, sb.releases, sb.longest_run);
    if (!failed) begin
      $display("think_block_stripper: match");
    end else begin
      $display("think_block_stripper: mismatch");
    end
    $finish;
  end

endmodule
